FILE: rtl/core/stereo_biquad_cascade_core_assert.svh
// Assertion macros shared by the core.
`ifndef STEREO_BIQUAD_CASCADE_CORE_ASSERT_SVH
`define STEREO_BIQUAD_CASCADE_CORE_ASSERT_SVH

`define SBC_ASSERT_IMP(label, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) else $error(msg);

`define SBC_ASSERT_NXT(label, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) else $error(msg);

`endif

FILE: rtl/core/sbc_pkg.sv
package sbc_pkg;

  localparam int MAX_SECTIONS  = 8;
  localparam int COEFS_PER_SEC = 5;
  localparam int COEF_DEPTH    = MAX_SECTIONS * COEFS_PER_SEC;
  localparam int COEF_AW       = $clog2(COEF_DEPTH);
  localparam int HIST_DEPTH    = 4 * MAX_SECTIONS;
  localparam int HIST_AW       = $clog2(HIST_DEPTH);
  localparam int CNT_W         = $clog2(MAX_SECTIONS + 1);

  localparam logic [1:0] OP_FILTER = 2'd0;
  localparam logic [1:0] OP_COEF   = 2'd1;
  localparam logic [1:0] OP_CLEAR  = 2'd2;

  localparam logic [2:0] SLOT_B0 = 3'd0;
  localparam logic [2:0] SLOT_A2 = 3'd4;

  localparam logic [2:0] STEP_NONE = 3'd0;
  localparam logic [2:0] STEP_B0   = 3'd1;
  localparam logic [2:0] STEP_B1   = 3'd2;
  localparam logic [2:0] STEP_B2   = 3'd3;
  localparam logic [2:0] STEP_A1   = 3'd4;
  localparam logic [2:0] STEP_A2   = 3'd5;
  localparam logic [2:0] STEP_WB   = 3'd6;

  localparam logic [2:0] REG_SECTION_COUNT = 3'd0;

  typedef struct packed {
    logic [1:0]         opcode;
    logic signed [23:0] left_in;
    logic signed [23:0] right_in;
    logic [2:0]         coef_section;
    logic [2:0]         coef_slot;
    logic signed [31:0] coef_value;
  } req_t;

  typedef struct packed {
    logic signed [23:0] left_out;
    logic signed [23:0] right_out;
  } res_t;

  typedef struct packed {
    logic [2:0] step;
    logic       load_x;
    logic       adv_x;
  } dp_ctrl_t;

endpackage

FILE: rtl/core/sbc_ram.sv
module sbc_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: rtl/core/sbc_datapath.sv
module sbc_datapath import sbc_pkg::*; (
  input  logic               clk,
  input  dp_ctrl_t           ctrl,
  input  logic signed [31:0] coef,
  input  logic signed [47:0] hist,
  input  logic signed [31:0] x_init,
  output logic signed [47:0] z1_new,
  output logic signed [47:0] z2_new,
  output logic signed [23:0] y_out24
);

  logic signed [31:0] x;
  logic signed [31:0] y;
  logic signed [63:0] prod;
  logic signed [47:0] h0;
  logic signed [47:0] h1;
  logic signed [53:0] za;
  logic signed [53:0] zb;

  logic signed [31:0] opb;
  logic signed [63:0] mul;
  logic signed [51:0] prod_q;
  logic signed [53:0] acc;
  logic signed [37:0] acc_q;
  logic signed [32:0] rnd;
  logic signed [31:0] rnd_q;

  function automatic logic signed [31:0] sat32(input logic signed [37:0] v);
    if (v[37:31] != {7{v[31]}}) begin
      return v[37] ? 32'sh8000_0000 : 32'sh7fff_ffff;
    end
    return v[31:0];
  endfunction

  function automatic logic signed [47:0] sat48(input logic signed [53:0] v);
    if (v[53:47] != {7{v[47]}}) begin
      return v[53] ? {1'b1, 47'd0} : {1'b0, {47{1'b1}}};
    end
    return v[47:0];
  endfunction

  function automatic logic signed [23:0] sat24(input logic signed [31:0] v);
    if (v[31:23] != {9{v[23]}}) begin
      return v[31] ? 24'sh80_0000 : 24'sh7f_ffff;
    end
    return v[23:0];
  endfunction

  assign opb    = (ctrl.step == STEP_A1 || ctrl.step == STEP_A2) ? y : x;
  assign mul    = coef * opb;
  assign prod_q = prod[63:12];
  assign acc    = 54'(prod_q) + 54'(h0) + 54'sd32768;
  assign acc_q  = acc[53:16];
  assign rnd    = 33'(y) + 33'sd1;
  assign rnd_q  = rnd[32:1];

  assign z1_new  = sat48(za);
  assign z2_new  = sat48(zb);
  assign y_out24 = sat24(rnd_q);

  always_ff @(posedge clk) begin
    if (ctrl.load_x) begin
      x <= x_init;
    end else if (ctrl.adv_x) begin
      x <= y;
    end
    case (ctrl.step)
      STEP_B0: begin
        prod <= mul;
        h0   <= hist;
      end
      STEP_B1: begin
        y    <= sat32(acc_q);
        prod <= mul;
        h1   <= hist;
      end
      STEP_B2: begin
        za   <= 54'(prod_q) + 54'(h1);
        prod <= mul;
      end
      STEP_A1: begin
        zb   <= 54'(prod_q);
        prod <= mul;
      end
      STEP_A2: begin
        za   <= za - 54'(prod_q);
        prod <= mul;
      end
      STEP_WB: begin
        zb <= zb - 54'(prod_q);
      end
      default: begin
      end
    endcase
  end

endmodule

FILE: rtl/core/stereo_biquad_cascade_core.sv
// A filter request passes the left and then the right sample through n sections, n being the
// number of sections in use; coefficient and clear requests are carried out at acceptance.
// Throughput: one request at a time, set by the single shared multiplier, which does the five
// products of each section on six steps through the coefficient and history memories.
// Reset (synchronous, active high) empties the output, sets section_count to zero and marks
// every coefficient and history word as zero through valid bits; no clearing pass is run.
`include "stereo_biquad_cascade_core_assert.svh"

module stereo_biquad_cascade_core import sbc_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        req_valid,
  output logic        req_stall,
  input  req_t        req,
  output logic        res_valid,
  input  logic        res_stall,
  output res_t        res,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_RUN    = 2'd1;
  localparam logic [1:0] ST_FINISH = 2'd2;

  logic [1:0]            state;
  logic [2:0]            step;
  logic [CNT_W-1:0]      sec;
  logic                  chan;
  logic [CNT_W-1:0]      n_reg;
  logic signed [31:0]    right_x;
  logic signed [23:0]    left_res;
  logic signed [23:0]    right_res;
  logic                  pend;
  logic [HIST_AW-1:0]    pend_addr;
  logic [COEF_DEPTH-1:0] coef_vld;
  logic [HIST_DEPTH-1:0] hist_vld;
  logic                  coef_rv;
  logic                  hist_rv;
  logic [3:0]            section_count;

  logic                  acc_req;
  logic                  at_wb;
  logic                  last_sec;
  logic [CNT_W-1:0]      nxt_sec;
  logic                  nxt_ch;
  logic [CNT_W-1:0]      n_eff;
  logic [COEF_AW-1:0]    coef_raddr;
  logic [COEF_AW-1:0]    coef_waddr;
  logic                  coef_we;
  logic [31:0]           coef_rdata;
  logic [HIST_AW-1:0]    hist_raddr;
  logic [HIST_AW-1:0]    hist_waddr;
  logic                  hist_we;
  logic [47:0]           hist_wdata;
  logic [47:0]           hist_rdata;
  logic signed [31:0]    coef_q;
  logic signed [47:0]    hist_q;
  logic signed [31:0]    x_init;
  logic signed [47:0]    z1_new;
  logic signed [47:0]    z2_new;
  logic signed [23:0]    y_out24;
  dp_ctrl_t              dp_ctrl;

  function automatic logic [COEF_AW-1:0] caddr(input int s, input int slot);
    return COEF_AW'(s * COEFS_PER_SEC + slot);
  endfunction

  function automatic logic [HIST_AW-1:0] haddr(input int ch, input int s, input int w);
    return HIST_AW'((ch * MAX_SECTIONS + s) * 2 + w);
  endfunction

  assign acc_req   = req_valid && !req_stall;
  assign req_stall = (state != ST_IDLE);
  assign at_wb     = (state == ST_RUN) && (step == STEP_WB);
  assign last_sec  = (sec == n_reg - CNT_W'(1));
  assign nxt_sec   = last_sec ? '0 : sec + CNT_W'(1);
  assign nxt_ch    = last_sec ? 1'b1 : chan;
  assign n_eff     = (int'(section_count) > MAX_SECTIONS) ? CNT_W'(MAX_SECTIONS)
                                                          : CNT_W'(section_count);

  always_comb begin
    coef_raddr = caddr(0, int'(SLOT_B0));
    hist_raddr = haddr(0, 0, 0);
    if (state == ST_RUN) begin
      if (step == STEP_WB) begin
        coef_raddr = caddr(int'(nxt_sec), int'(SLOT_B0));
        hist_raddr = haddr(int'(nxt_ch), int'(nxt_sec), 0);
      end else begin
        coef_raddr = caddr(int'(sec), int'(step));
        hist_raddr = haddr(int'(chan), int'(sec), 1);
      end
    end
  end

  assign coef_we    = acc_req && (req.opcode == OP_COEF)
                      && (int'(req.coef_section) < MAX_SECTIONS) && (req.coef_slot <= SLOT_A2);
  assign coef_waddr = caddr(int'(req.coef_section), int'(req.coef_slot));

  assign hist_we    = at_wb || pend;
  assign hist_waddr = at_wb ? haddr(int'(chan), int'(sec), 0) : pend_addr;
  assign hist_wdata = at_wb ? z1_new : z2_new;

  assign coef_q = coef_rv ? coef_rdata : '0;
  assign hist_q = hist_rv ? hist_rdata : '0;
  assign x_init = (state == ST_IDLE) ? {{7{req.left_in[23]}}, req.left_in, 1'b0} : right_x;

  assign dp_ctrl.step   = (state == ST_RUN) ? step : STEP_NONE;
  assign dp_ctrl.load_x = (acc_req && req.opcode == OP_FILTER) || (at_wb && last_sec && !chan);
  assign dp_ctrl.adv_x  = at_wb && !last_sec;

  sbc_ram #(
    .WIDTH(32),
    .DEPTH(COEF_DEPTH)
  ) u_coef_ram (
    .clk  (clk),
    .we   (coef_we),
    .waddr(coef_waddr),
    .wdata(req.coef_value),
    .raddr(coef_raddr),
    .rdata(coef_rdata)
  );

  sbc_ram #(
    .WIDTH(48),
    .DEPTH(HIST_DEPTH)
  ) u_hist_ram (
    .clk  (clk),
    .we   (hist_we),
    .waddr(hist_waddr),
    .wdata(hist_wdata),
    .raddr(hist_raddr),
    .rdata(hist_rdata)
  );

  sbc_datapath u_datapath (
    .clk    (clk),
    .ctrl   (dp_ctrl),
    .coef   (coef_q),
    .hist   (hist_q),
    .x_init (x_init),
    .z1_new (z1_new),
    .z2_new (z2_new),
    .y_out24(y_out24)
  );

  always_ff @(posedge clk) begin
    coef_rv   <= coef_vld[coef_raddr];
    hist_rv   <= hist_vld[hist_raddr];
    pend_addr <= haddr(int'(chan), int'(sec), 1);
    if (rst) begin
      coef_vld <= '0;
      hist_vld <= '0;
      pend     <= 1'b0;
    end else begin
      pend <= at_wb;
      if (coef_we) begin
        coef_vld[coef_waddr] <= 1'b1;
      end
      if (acc_req && req.opcode == OP_CLEAR) begin
        hist_vld <= '0;
      end else if (hist_we) begin
        hist_vld[hist_waddr] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      step  <= STEP_NONE;
      sec   <= '0;
      chan  <= 1'b0;
      n_reg <= '0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (acc_req && req.opcode == OP_FILTER) begin
            n_reg   <= n_eff;
            right_x <= {{7{req.right_in[23]}}, req.right_in, 1'b0};
            sec     <= '0;
            chan    <= 1'b0;
            if (n_eff == '0) begin
              left_res  <= req.left_in;
              right_res <= req.right_in;
              state     <= ST_FINISH;
            end else begin
              step  <= STEP_B0;
              state <= ST_RUN;
            end
          end
        end
        ST_RUN: begin
          if (step == STEP_WB) begin
            sec  <= nxt_sec;
            step <= STEP_B0;
            if (last_sec) begin
              if (!chan) begin
                left_res <= y_out24;
                chan     <= 1'b1;
              end else begin
                right_res <= y_out24;
                step      <= STEP_NONE;
                state     <= ST_FINISH;
              end
            end
          end else begin
            step <= step + 3'd1;
          end
        end
        ST_FINISH: begin
          if (!res_valid || !res_stall) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (state == ST_FINISH && (!res_valid || !res_stall)) begin
      res_valid     <= 1'b1;
      res.left_out  <= left_res;
      res.right_out <= right_res;
    end else if (!res_stall) begin
      res_valid <= 1'b0;
    end
  end

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      section_count <= 4'd0;
    end else if (psel && penable && pwrite && paddr == REG_SECTION_COUNT) begin
      section_count <= pwdata[3:0];
    end
  end

  assign prdata = (paddr == REG_SECTION_COUNT) ? {28'd0, section_count} : 32'd0;

  `SBC_ASSERT_IMP(a_wb_no_pend, at_wb, !pend, "history write-back collides with pending write")
  `SBC_ASSERT_IMP(a_sec_range, state == ST_RUN, sec < n_reg, "section index beyond count")
  `SBC_ASSERT_NXT(a_filter_starts, acc_req && req.opcode == OP_FILTER, state == ST_RUN || state == ST_FINISH, "filter request did not start")
  `SBC_ASSERT_IMP(a_res_from_finish, $rose(res_valid), $past(state) == ST_FINISH, "result raised outside finish")

endmodule
